[sv/sorted_priority_queue_defines.svh]
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// check sampled on clk, switched off while rst_n is low
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check sampled on clk, also active during reset
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[sv/spq_pkg.sv]
// shared types and constants of the sorted priority queue
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int PRI_W       = 16;
  localparam int OCC_W       = 5;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_ENQ = 2'd0,
    REQ_DEQ = 2'd1,
    REQ_CLR = 2'd2,
    REQ_QRY = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

endpackage

`default_nettype wire

[sv/spq_ifs.sv]
// request and result channel interfaces
`default_nettype none

interface spq_in_if;
  import spq_pkg::*;
  logic                     valid;
  logic                     ready;
  req_t                     req_type;
  logic signed [DATA_W-1:0] in_data;
  logic signed [PRI_W-1:0]  in_priority;

  modport source (output valid, output req_type, output in_data, output in_priority,
                  input ready);
  modport sink   (input valid, input req_type, input in_data, input in_priority,
                  output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] item_data;
  logic signed [PRI_W-1:0]  item_priority;
  logic                     item_valid;
  status_t                  status;
  logic [OCC_W-1:0]         occupancy;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output item_data, output item_priority,
                  output item_valid, output status, output occupancy,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input item_data, input item_priority,
                  input item_valid, input status, input occupancy,
                  input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

[sv/spq_ctrl.sv]
// request sequencing: accept, execute, hold result until taken
`default_nettype none

module spq_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output spq_pkg::ctl_t     ctl
);
  import spq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  // take a request once the result slot is free or being emptied
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign ctl.load  = in_valid && in_ready;
  assign ctl.exec  = (state_r == S_EXEC);
  assign out_valid = out_valid_r;

  // state and result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (in_valid && in_ready) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/spq_dpath.sv]
// sorted entry row with parallel compare, shift and result registers
`default_nettype none

module spq_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire spq_pkg::ctl_t                     ctl,
  input  wire spq_pkg::req_t                     req_type,
  input  wire logic signed [spq_pkg::DATA_W-1:0] in_data,
  input  wire logic signed [spq_pkg::PRI_W-1:0]  in_priority,
  output logic signed [spq_pkg::DATA_W-1:0]      item_data,
  output logic signed [spq_pkg::PRI_W-1:0]       item_priority,
  output logic                                   item_valid,
  output spq_pkg::status_t                       status,
  output logic [spq_pkg::OCC_W-1:0]              occupancy,
  output logic                                   is_empty,
  output logic                                   is_full
);
  import spq_pkg::*;

  // latched request
  req_t                     req_r;
  logic signed [DATA_W-1:0] dat_r;
  logic signed [PRI_W-1:0]  pri_r;

  // entry row, slot 0 is the front
  logic signed [DATA_W-1:0] ent_dat_r   [QUEUE_DEPTH];
  logic signed [PRI_W-1:0]  ent_pri_r   [QUEUE_DEPTH];
  logic signed [DATA_W-1:0] ent_dat_nxt [QUEUE_DEPTH];
  logic signed [PRI_W-1:0]  ent_pri_nxt [QUEUE_DEPTH];
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;

  // result registers
  logic signed [DATA_W-1:0] res_dat_r, res_dat_nxt;
  logic signed [PRI_W-1:0]  res_pri_r, res_pri_nxt;
  logic                     res_vld_r, res_vld_nxt;
  status_t                  res_st_r, res_st_nxt;

  logic [QUEUE_DEPTH-1:0]   shift;
  logic                     cnt_full;
  logic                     cnt_zero;
  logic                     do_enq;
  logic                     do_deq;

  assign cnt_full = (count_r == CNT_W'(QUEUE_DEPTH));
  assign cnt_zero = (count_r == '0);
  assign do_enq   = ctl.exec && (req_r == REQ_ENQ) && !cnt_full;
  assign do_deq   = ctl.exec && (req_r == REQ_DEQ) && !cnt_zero;

  // per slot: compare with new priority and pick the next contents
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
    logic                     prev_shift;
    logic signed [DATA_W-1:0] prev_dat, next_dat;
    logic signed [PRI_W-1:0]  prev_pri, next_pri;

    // an entry moves back when the new item outranks it
    assign shift[g] = (CNT_W'(g) < count_r) && (pri_r > ent_pri_r[g]);

    if (g == 0) begin : g_head
      assign prev_shift = 1'b0;
      assign prev_dat   = ent_dat_r[g];
      assign prev_pri   = ent_pri_r[g];
    end else begin : g_body
      assign prev_shift = shift[g-1];
      assign prev_dat   = ent_dat_r[g-1];
      assign prev_pri   = ent_pri_r[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign next_dat = ent_dat_r[g];
      assign next_pri = ent_pri_r[g];
    end else begin : g_mid
      assign next_dat = ent_dat_r[g+1];
      assign next_pri = ent_pri_r[g+1];
    end

    always_comb begin
      ent_dat_nxt[g] = ent_dat_r[g];
      ent_pri_nxt[g] = ent_pri_r[g];
      if (do_enq) begin
        if (prev_shift) begin
          ent_dat_nxt[g] = prev_dat;
          ent_pri_nxt[g] = prev_pri;
        end else if (shift[g] || (CNT_W'(g) == count_r)) begin
          ent_dat_nxt[g] = dat_r;
          ent_pri_nxt[g] = pri_r;
        end
      end else if (do_deq) begin
        ent_dat_nxt[g] = next_dat;
        ent_pri_nxt[g] = next_pri;
      end
    end
  end

  // next count and the reported item
  always_comb begin
    count_nxt   = count_r;
    res_st_nxt  = ST_OK;
    res_vld_nxt = !cnt_zero;
    res_dat_nxt = ent_dat_r[0];
    res_pri_nxt = ent_pri_r[0];
    case (req_r)
      REQ_ENQ: begin
        if (cnt_full) begin
          res_st_nxt = ST_FULL;
        end else begin
          count_nxt   = count_r + CNT_W'(1);
          res_vld_nxt = 1'b1;
          if (cnt_zero || shift[0]) begin
            res_dat_nxt = dat_r;
            res_pri_nxt = pri_r;
          end
        end
      end
      REQ_DEQ: begin
        if (cnt_zero) begin
          res_st_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_CLR: begin
        count_nxt   = '0;
        res_vld_nxt = 1'b0;
      end
      REQ_QRY: begin
        count_nxt = count_r;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    // no entry to report: zero the fields
    if (!res_vld_nxt) begin
      res_dat_nxt = '0;
      res_pri_nxt = '0;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_r <= req_type;
      dat_r <= in_data;
      pri_r <= in_priority;
    end
  end

  // entry row update
  always_ff @(posedge clk) begin
    if (do_enq || do_deq) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        ent_dat_r[i] <= ent_dat_nxt[i];
        ent_pri_r[i] <= ent_pri_nxt[i];
      end
    end
  end

  // occupancy count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.exec) begin
      count_r <= count_nxt;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      res_dat_r <= res_dat_nxt;
      res_pri_r <= res_pri_nxt;
      res_vld_r <= res_vld_nxt;
      res_st_r  <= res_st_nxt;
    end
  end

  assign item_data     = res_dat_r;
  assign item_priority = res_pri_r;
  assign item_valid    = res_vld_r;
  assign status        = res_st_r;
  assign occupancy     = OCC_W'(count_r);
  assign is_empty      = (count_r == '0);
  assign is_full       = (count_r == CNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

[sv/sorted_priority_queue.sv]
// sorted priority queue: 16 entries, highest priority at the front, ties kept in order
// result path: an accepted request is latched, executed in S_EXEC, then registered and offered until taken
// one request at a time: no new request is taken while one executes, set by the single request register
//   of the accept/execute sequencer; a waiting result blocks the next accept unless it is taken in the same cycle
// reset: synchronous active-low rst_n clears the sequencer, result valid and entry count;
//   entry storage is not cleared and is only read below the count
`default_nettype none

`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue (
  input  wire logic clk,
  input  wire logic rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  ctl_t ctl;

  // sequencer
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl)
  );

  // entry row and result registers
  spq_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .req_type      (in_ch.req_type),
    .in_data       (in_ch.in_data),
    .in_priority   (in_ch.in_priority),
    .item_data     (out_ch.item_data),
    .item_priority (out_ch.item_priority),
    .item_valid    (out_ch.item_valid),
    .status        (out_ch.status),
    .occupancy     (out_ch.occupancy),
    .is_empty      (out_ch.is_empty),
    .is_full       (out_ch.is_full)
  );

  // one item in flight at a time
  `SPQ_ASSERT(a_one_in_flight, in_ch.valid && in_ch.ready |=> !in_ch.ready, "second item accepted while busy")
  // every accepted item is followed by a valid result
  `SPQ_ASSERT(a_result_follows, in_ch.valid && in_ch.ready |-> ##2 out_ch.valid, "result missing after accept")
  // an empty queue reports no entry unless a dequeue removed one
  `SPQ_ASSERT(a_empty_no_item, out_ch.valid && out_ch.is_empty && out_ch.status != ST_OK |-> !out_ch.item_valid, "item reported from empty queue")
  // no entry means zeroed fields
  `SPQ_ASSERT(a_invalid_zero, out_ch.valid && !out_ch.item_valid |-> out_ch.item_data == 0 && out_ch.item_priority == 0, "invalid item not zeroed")
  // no result shown straight out of reset
  `SPQ_ASSERT_ALWAYS(a_reset_idle, !$past(rst_n) |-> !out_ch.valid, "result valid after reset")

endmodule

`default_nettype wire

[dv/sorted_priority_queue_tb.sv]
// self-checking testbench of the sorted priority queue, with directed and random requests
`timescale 1ns / 100ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;

  typedef struct packed {
    logic signed [DATA_W-1:0] item_data;
    logic signed [PRI_W-1:0]  item_priority;
    logic                     item_valid;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_empty;
    logic                     is_full;
  } pq_result_t;

  logic clk;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the sorted entries
  logic signed [DATA_W-1:0] shadow_data [QUEUE_DEPTH];
  logic signed [PRI_W-1:0]  shadow_pri  [QUEUE_DEPTH];
  int                       shadow_count;

  pq_result_t pending_results [$];
  int         fail_count;
  int         stall_cycles;
  int         src_idle_pct;
  int         sink_stall_pct;
  int         hold_request;
  int         hold_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // works out the answer to one request and updates the shadow queue
  function automatic pq_result_t pq_predict(req_t req, logic signed [DATA_W-1:0] d,
                                            logic signed [PRI_W-1:0] p);
    pq_result_t res;
    int         pos;
    logic       reported;
    res          = '0;
    res.status   = ST_OK;
    reported     = 1'b0;
    case (req)
      REQ_ENQ: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // new entry goes behind all entries of equal or higher priority
          pos = shadow_count;
          while (pos > 0 && p > shadow_pri[pos-1]) begin
            shadow_data[pos] = shadow_data[pos-1];
            shadow_pri[pos]  = shadow_pri[pos-1];
            pos--;
          end
          shadow_data[pos] = d;
          shadow_pri[pos]  = p;
          shadow_count++;
        end
      end
      REQ_DEQ: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.item_data     = shadow_data[0];
          res.item_priority = shadow_pri[0];
          res.item_valid    = 1'b1;
          for (int i = 1; i < shadow_count; i++) begin
            shadow_data[i-1] = shadow_data[i];
            shadow_pri[i-1]  = shadow_pri[i];
          end
          shadow_count--;
        end
        reported = 1'b1;
      end
      REQ_CLR: begin
        shadow_count = 0;
      end
      default: ;
    endcase
    // everything but a dequeue reports the front after the request
    if (!reported && shadow_count > 0) begin
      res.item_data     = shadow_data[0];
      res.item_priority = shadow_pri[0];
      res.item_valid    = 1'b1;
    end
    res.occupancy = OCC_W'(shadow_count);
    res.is_empty  = (shadow_count == 0);
    res.is_full   = (shadow_count == QUEUE_DEPTH);
    return res;
  endfunction

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // accepted requests feed the predictor, accepted results are checked in order
  always @(posedge clk) begin
    pq_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(pq_predict(in_ch.req_type, in_ch.in_data,
                                             in_ch.in_priority));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result item with nothing expected");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("item_data", want.item_data, out_ch.item_data);
          check_field("item_priority", want.item_priority, out_ch.item_priority);
          check_field("item_valid", want.item_valid, out_ch.item_valid);
          check_field("status", want.status, out_ch.status);
          check_field("occupancy", want.occupancy, out_ch.occupancy);
          check_field("is_empty", want.is_empty, out_ch.is_empty);
          check_field("is_full", want.is_full, out_ch.is_full);
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  // watchdog on cycles with no item moving
  initial begin
    stall_cycles = 0;
    @(posedge rst_n);
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("sorted_priority_queue_tb NOT OK");
    $finish;
  end

  // result receiver: random stalls, plus a long hold-off on request
  initial begin
    hold_left     = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // offers one request and waits until it is taken
  task automatic send_request(req_t req, logic signed [DATA_W-1:0] d,
                              logic signed [PRI_W-1:0] p);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= req;
    in_ch.in_data     <= d;
    in_ch.in_priority <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // mostly full-range, some extremes
  function automatic logic signed [DATA_W-1:0] pick_data();
    case ($urandom_range(19))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // small range often, so that equal priorities are common
  function automatic logic signed [PRI_W-1:0] pick_priority();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return PRI_W'($signed($urandom_range(4)) - 2);
    if (roll < 45) return 16'sh7fff;
    if (roll < 50) return 16'sh8000;
    return PRI_W'($urandom_range(16'hffff));
  endfunction

  // requests on a queue that is still empty
  task automatic test_empty_requests();
    send_request(REQ_DEQ, pick_data(), pick_priority());
    send_request(REQ_QRY, pick_data(), pick_priority());
    send_request(REQ_CLR, pick_data(), pick_priority());
  endtask

  // fill to the top with extremes and ties, then try one more
  task automatic test_fill_ties_and_overflow();
    logic signed [PRI_W-1:0] pri_list [QUEUE_DEPTH] = '{
      16'sh7fff, 16'sh8000, 0, -1, 0, 0, 16'sh7fff, 16'sh8000,
      5, 5, 1, -1, 100, -100, 0, 2};
    logic signed [DATA_W-1:0] data_list [4] = '{
      32'sh7fff_ffff, 32'sh8000_0000, 0, -1};
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_request(REQ_ENQ, (i < 4) ? data_list[i] : DATA_W'(i * 32'h1111_1111), pri_list[i]);
    end
    send_request(REQ_ENQ, 32'sh5555_aaaa, 16'sh7fff);
    send_request(REQ_QRY, 0, 0);
  endtask

  // take a couple off, wipe, then dequeue from empty
  task automatic test_drain_and_clear();
    send_request(REQ_DEQ, 0, 0);
    send_request(REQ_DEQ, 0, 0);
    send_request(REQ_CLR, 0, 0);
    send_request(REQ_DEQ, 0, 0);
    send_request(REQ_QRY, 0, 0);
  endtask

  // receiver holds off while requests keep coming, so the input backs up
  task automatic test_full_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_request   = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) begin
      send_request(($urandom_range(3) == 0) ? REQ_DEQ : REQ_ENQ, pick_data(),
                   pick_priority());
    end
  endtask

  // bursts that lean to filling, draining or neither
  task automatic test_random_traffic(int n_items, int src_pct, int sink_pct);
    int   mode;
    int   burst_left;
    int   roll;
    req_t req;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    burst_left     = 0;
    mode           = 0;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        mode       = $urandom_range(2);
        burst_left = $urandom_range(24, 8);
      end
      burst_left--;
      roll = $urandom_range(99);
      case (mode)
        0:       req = (roll < 78) ? REQ_ENQ : (roll < 91) ? REQ_DEQ :
                       (roll < 99) ? REQ_QRY : REQ_CLR;
        1:       req = (roll < 20) ? REQ_ENQ : (roll < 90) ? REQ_DEQ :
                       (roll < 98) ? REQ_QRY : REQ_CLR;
        default: req = (roll < 45) ? REQ_ENQ : (roll < 85) ? REQ_DEQ :
                       (roll < 97) ? REQ_QRY : REQ_CLR;
      endcase
      send_request(req, pick_data(), pick_priority());
    end
  endtask

  // test sequence
  initial begin
    fail_count         = 0;
    shadow_count       = 0;
    hold_request       = 0;
    src_idle_pct       = 16;
    sink_stall_pct     = 53;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_QRY;
    in_ch.in_data     <= '0;
    in_ch.in_priority <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_requests();
    test_fill_ties_and_overflow();
    test_drain_and_clear();
    test_full_backpressure();
    test_random_traffic(480, 16, 53);
    test_random_traffic(480, 53, 16);
    test_random_traffic(480, 0, 0);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    // every accepted request must have had its result
    if (pending_results.size() != 0) begin
      $error("results outstanding at end: expected %0d, got %0d", 0, pending_results.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("sorted_priority_queue_tb OK");
    end else begin
      $display("sorted_priority_queue_tb NOT OK");
    end
    $finish;
  end

endmodule
